// ===== hdl/hcbp_pkg.sv =====
`default_nettype none
package hcbp_pkg;

	localparam int DEF_MAX_CODE_LEN = 32;
	localparam int DEF_SYMBOLS      = 256;

	localparam int ACT_W     = 2;
	localparam int SYM_W     = 8;
	localparam int CODE_IN_W = 32;
	localparam int LEN_W     = 6;
	localparam int BYTE_W    = 8;
	localparam int PEND_BITS = 7;
	localparam int PCNT_W    = 3;
	localparam int FILL_W    = 7;
	localparam int IN_W      = SYM_W + CODE_IN_W + LEN_W;
	localparam int TDATA_W   = ((IN_W + BYTE_W - 1) / BYTE_W) * BYTE_W;

	localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_ENCODE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_FLUSH  = 2'd2;

endpackage
`default_nettype wire

// ===== hdl/huffman_code_bit_packer.sv =====
// Huffman code bit packer: LSB-first packing of table-driven codes into bytes.
// Input stream (s_*): s_tuser carries the action, s_tdata the symbol,
// code_bits and code_len. A load writes one code table entry, an encode looks
// the symbol up and appends its code bits at the current fill position, a
// flush sends the partial byte with its unused high bits cleared.
// Output stream (m_*): one packed byte per transfer, earliest bit in bit 0;
// tlast marks the final byte produced by one input request.
// Timing: the table is read at the edge that accepts an encode and the bytes
// are packed into the emitter at a later edge, once it is free; m_tvalid
// comes from the emitter's registered byte count.
// Throughput: one input request per cycle while each produces at most one
// byte and the receiver is ready; a request producing two or more bytes (up
// to four with 32-bit codes) holds the pipe until the byte-wide output emitter sends its last byte.
// A load followed at once by an encode of the same symbol sees the new entry:
// the write lands at the edge that accepts the load.
// Reset clears the pending bits, the fill count and all valid flags; the code
// table is not cleared and must be loaded before its entries are encoded.
// When the receiver stalls, the emitter holds its bytes, the packing stage
// holds its request, and s_tready drops once both are full.
`default_nettype none
module huffman_code_bit_packer #(
	parameter int MAX_CODE_LEN = hcbp_pkg::DEF_MAX_CODE_LEN,
	parameter int SYMBOLS      = hcbp_pkg::DEF_SYMBOLS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// symbol[7:0], code_bits[39:8], code_len[45:40], zero[47:46]
	input  wire logic [hcbp_pkg::TDATA_W-1:0]  s_tdata,
	// action[1:0]
	input  wire logic [hcbp_pkg::ACT_W-1:0]    s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// out_byte[7:0]
	output logic      [hcbp_pkg::BYTE_W-1:0]   m_tdata,
	// last
	output logic                               m_tlast
);
	import hcbp_pkg::*;

	localparam int CODE_W = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
	localparam int AW     = $clog2(SYMBOLS);
	localparam int ACC_W  = PEND_BITS + CODE_W;
	localparam int BYTES  = ACC_W / BYTE_W;
	localparam int EMIT_W = BYTES * BYTE_W;
	localparam int CNT_W  = $clog2(BYTES + 1);

	// unpack the input request
	logic [ACT_W-1:0]     in_act;
	logic [SYM_W-1:0]     in_sym;
	logic [CODE_IN_W-1:0] in_bits;
	logic [LEN_W-1:0]     in_len;

	assign in_act  = s_tuser;
	assign in_sym  = s_tdata[SYM_W-1:0];
	assign in_bits = s_tdata[SYM_W+CODE_IN_W-1:SYM_W];
	assign in_len  = s_tdata[IN_W-1:SYM_W+CODE_IN_W];

	logic in_take, in_rng;
	logic valid_s1, inrng_s1;
	logic [ACT_W-1:0] act_s1;
	logic adv, push, emit_free;
	logic [EMIT_W-1:0] push_data;
	logic [CNT_W-1:0]  push_n;
	logic [LEN_W-1:0]  rd_len;
	logic [CODE_W-1:0] rd_bits;

	// accept when the packing stage is empty or moves on this cycle
	assign s_tready = !valid_s1 || adv;
	assign in_take  = s_tvalid && s_tready;
	// symbols beyond the table are dropped on load and produce nothing on encode
	assign in_rng   = ({1'b0, in_sym} < (SYM_W + 1)'(SYMBOLS));

	hcbp_table #(
		.MAX_CODE_LEN (MAX_CODE_LEN),
		.SYMBOLS      (SYMBOLS),
		.CODE_W       (CODE_W),
		.AW           (AW)
	) u_table (
		.clk     (clk),
		.wr_en   (in_take && (in_act == ACT_LOAD) && in_rng),
		.rd_en   (in_take && (in_act == ACT_ENCODE) && in_rng),
		.addr    (in_sym[AW-1:0]),
		.wr_bits (in_bits),
		.wr_len  (in_len),
		.rd_len  (rd_len),
		.rd_bits (rd_bits)
	);

	// stage 1: the request waits here while its table entry is read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			act_s1   <= in_act;
			inrng_s1 <= in_rng;
		end
	end

	hcbp_pack #(
		.CODE_W (CODE_W),
		.EMIT_W (EMIT_W),
		.CNT_W  (CNT_W)
	) u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.act_s1    (act_s1),
		.inrng_s1  (inrng_s1),
		.rd_len    (rd_len),
		.rd_bits   (rd_bits),
		.emit_free (emit_free),
		.adv       (adv),
		.push      (push),
		.push_data (push_data),
		.push_n    (push_n)
	);

	hcbp_emit #(
		.EMIT_W (EMIT_W),
		.CNT_W  (CNT_W)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.push_n    (push_n),
		.emit_free (emit_free),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
`default_nettype wire

// ===== hdl/hcbp_table.sv =====
`default_nettype none
module hcbp_table #(
	parameter int MAX_CODE_LEN = hcbp_pkg::DEF_MAX_CODE_LEN,
	parameter int SYMBOLS      = hcbp_pkg::DEF_SYMBOLS,
	parameter int CODE_W       = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32,
	parameter int AW           = $clog2(SYMBOLS)
) (
	input  wire logic                        clk,
	input  wire logic                        wr_en,
	input  wire logic                        rd_en,
	input  wire logic [AW-1:0]               addr,
	input  wire logic [hcbp_pkg::CODE_IN_W-1:0] wr_bits,
	input  wire logic [hcbp_pkg::LEN_W-1:0]  wr_len,
	output logic      [hcbp_pkg::LEN_W-1:0]  rd_len,
	output logic      [CODE_W-1:0]           rd_bits
);
	import hcbp_pkg::*;

	localparam int ENT_W = LEN_W + CODE_W;
	localparam logic [LEN_W-1:0] LEN_LIM = LEN_W'(CODE_W);

	logic [ENT_W-1:0] mem [SYMBOLS];
	logic [ENT_W-1:0] rd_q;
	logic [LEN_W-1:0] len_sat;
	logic [CODE_W-1:0] bits_msk;

	// saturate the length, drop code bits at or above it
	always_comb begin
		len_sat = (wr_len > LEN_LIM) ? LEN_LIM : wr_len;
		for (int i = 0; i < CODE_W; i++) begin
			bits_msk[i] = wr_bits[i] & (LEN_W'(i) < len_sat);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= {len_sat, bits_msk};
		end
		if (rd_en) begin
			rd_q <= mem[addr];
		end
	end

	assign rd_len  = rd_q[ENT_W-1:CODE_W];
	assign rd_bits = rd_q[CODE_W-1:0];

endmodule
`default_nettype wire

// ===== hdl/hcbp_pack.sv =====
`default_nettype none
module hcbp_pack #(
	parameter int CODE_W = 32,
	parameter int EMIT_W = 32,
	parameter int CNT_W  = 3
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          valid_s1,
	input  wire logic [hcbp_pkg::ACT_W-1:0]    act_s1,
	input  wire logic                          inrng_s1,
	input  wire logic [hcbp_pkg::LEN_W-1:0]    rd_len,
	input  wire logic [CODE_W-1:0]             rd_bits,
	input  wire logic                          emit_free,
	output logic                               adv,
	output logic                               push,
	output logic      [EMIT_W-1:0]             push_data,
	output logic      [CNT_W-1:0]              push_n
);
	import hcbp_pkg::*;

	localparam int ACC_W = PEND_BITS + CODE_W;

	logic [PEND_BITS-1:0] pend_q, pend_nx;
	logic [PCNT_W-1:0]    cnt_q, cnt_nx;
	logic [ACC_W-1:0]     acc, rest;
	logic [FILL_W-1:0]    fill;
	logic [FILL_W-PCNT_W-1:0] nbytes;
	logic                 do_enc, do_flush;

	always_comb begin
		acc    = ACC_W'(pend_q) | (ACC_W'(rd_bits) << cnt_q);
		fill   = FILL_W'(cnt_q) + FILL_W'(rd_len);
		nbytes = fill[FILL_W-1:PCNT_W];
		rest   = acc >> {nbytes, 3'b000};
		do_enc   = (act_s1 == ACT_ENCODE) && inrng_s1 && (rd_len != '0);
		do_flush = (act_s1 == ACT_FLUSH) && (cnt_q != '0);

		pend_nx   = pend_q;
		cnt_nx    = cnt_q;
		push_n    = '0;
		push_data = acc[EMIT_W-1:0];
		if (do_enc) begin
			cnt_nx = fill[PCNT_W-1:0];
			for (int i = 0; i < PEND_BITS; i++) begin
				pend_nx[i] = rest[i] & (PCNT_W'(i) < fill[PCNT_W-1:0]);
			end
			push_n = CNT_W'(nbytes);
		end else if (do_flush) begin
			pend_nx   = '0;
			cnt_nx    = '0;
			push_n    = CNT_W'(1);
			push_data = EMIT_W'(pend_q);
		end
		// hold the item while the emitter still has bytes to send
		adv  = valid_s1 && ((push_n == '0) || emit_free);
		push = adv && (push_n != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			cnt_q  <= '0;
		end else if (adv) begin
			pend_q <= pend_nx;
			cnt_q  <= cnt_nx;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/hcbp_emit.sv =====
`default_nettype none
module hcbp_emit #(
	parameter int EMIT_W = 32,
	parameter int CNT_W  = 3
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	input  wire logic [EMIT_W-1:0]           push_data,
	input  wire logic [CNT_W-1:0]            push_n,
	output logic                             emit_free,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic      [hcbp_pkg::BYTE_W-1:0] m_tdata,
	output logic                             m_tlast
);
	import hcbp_pkg::*;

	logic [EMIT_W-1:0] buf_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              take;

	assign m_tvalid  = (cnt_q != '0);
	assign m_tdata   = buf_q[BYTE_W-1:0];
	assign m_tlast   = (cnt_q == CNT_W'(1));
	assign take      = m_tvalid && m_tready;
	assign emit_free = (cnt_q == '0) || (m_tlast && m_tready);

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q <= push_data;
		end else if (take) begin
			buf_q <= buf_q >> BYTE_W;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (push) begin
			cnt_q <= push_n;
		end else if (take) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

endmodule
`default_nettype wire
